@@ src/dtt_pkg.sv @@
package dtt_pkg;

    localparam int DATA_W   = 64;
    localparam int COUNT_W  = 11;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        FUNC_TRANSLATE = 2'd0,
        FUNC_PUT       = 2'd1,
        FUNC_GET       = 2'd2,
        FUNC_STUFF     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        NOTICE_NONE  = 2'd0,
        NOTICE_MAP   = 2'd1,
        NOTICE_UNMAP = 2'd2
    } notice_t;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES     = 2'd3;

    localparam logic [5:0]        PAGE_SHIFT_RESET = 6'hC;
    localparam logic [DATA_W-1:0] BUS_ID_HIGH_MASK = 64'hFFFFFFFF00000000;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_LOOK,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [31:0]       table_id;
        logic [5:0]        pg_bits;
        logic [DATA_W-1:0] window_base;
    } cfg_t;

    typedef struct packed {
        logic               status;
        logic [DATA_W-1:0]  entry_read;
        logic [DATA_W-1:0]  iova;
        logic [DATA_W-1:0]  phys_addr;
        logic [DATA_W-1:0]  offset_mask;
        logic [1:0]         perm;
        notice_t            notice;
        logic [COUNT_W-1:0] entries_written;
    } result_t;

endpackage

@@ src/dtt_store.sv @@
module dtt_store #(
    parameter int TABLE_DEPTH = 1024,
    parameter int IW          = 10
) (
    input  logic                   aclk,
    input  logic                   wr_en,
    input  logic                   rd_en,
    input  logic [IW-1:0]          addr,
    input  logic [dtt_pkg::DATA_W-1:0] wdata,
    output logic [dtt_pkg::DATA_W-1:0] rdata
);
    import dtt_pkg::*;

    logic [DATA_W-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end
        if (rd_en) begin
            rdata <= mem[addr];
        end
    end

endmodule

@@ src/dtt_addr_unit.sv @@
module dtt_addr_unit #(
    parameter int IW = 10,
    parameter int NW = 11
) (
    input  logic [dtt_pkg::DATA_W-1:0] op_a,
    input  logic [dtt_pkg::DATA_W-1:0] op_b,
    input  logic                       sub,
    output logic [dtt_pkg::DATA_W-1:0] sum,
    input  logic [dtt_pkg::DATA_W-1:0] shift_src,
    input  logic [5:0]                 shift_amt,
    input  logic [NW-1:0]              limit,
    output logic [IW-1:0]              idx,
    output logic                       in_range
);
    import dtt_pkg::*;

    logic [DATA_W-1:0] shifted;
    logic [DATA_W-1:0] high_part;

    assign sum       = sub ? (op_a - op_b) : (op_a + op_b);
    assign shifted   = shift_src >> shift_amt;
    assign high_part = shifted >> NW;
    assign idx       = shifted[IW-1:0];
    assign in_range  = (high_part == '0) && (shifted[NW-1:0] < limit);

endmodule

@@ src/dtt_seq.sv @@
module dtt_seq #(
    parameter int TABLE_DEPTH = 1024,
    parameter int IW          = 10,
    parameter int NW          = 11
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  dtt_pkg::func_t              in_func,
    input  logic [dtt_pkg::DATA_W-1:0]  in_bus_id,
    input  logic [dtt_pkg::DATA_W-1:0]  in_addr,
    input  logic [dtt_pkg::DATA_W-1:0]  in_entry_value,
    input  logic [dtt_pkg::COUNT_W-1:0] in_page_count,
    input  dtt_pkg::cfg_t               cfg,
    input  logic [NW-1:0]               live_entries,
    output logic                        res_valid,
    output dtt_pkg::result_t            res,
    input  logic                        out_free,
    output logic                        mem_wr_en,
    output logic                        mem_rd_en,
    output logic [IW-1:0]               mem_addr,
    output logic [dtt_pkg::DATA_W-1:0]  mem_wdata,
    input  logic [dtt_pkg::DATA_W-1:0]  mem_rdata
);
    import dtt_pkg::*;

    localparam logic [IW-1:0] CLR_LAST = IW'(TABLE_DEPTH - 1);

    state_t             state_reg, state_next;
    logic [IW-1:0]      clr_reg, clr_next;
    func_t              func_reg, func_next;
    logic               id_ok_reg, id_ok_next;
    logic [DATA_W-1:0]  addr_reg, addr_next;
    logic [DATA_W-1:0]  value_reg, value_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]  rel_reg, rel_next;
    result_t            res_reg, res_next;

    logic [DATA_W-1:0]  pg_align;
    logic [DATA_W-1:0]  page_step;
    logic [DATA_W-1:0]  op_a, op_b, sum;
    logic               op_sub;
    logic [IW-1:0]      idx;
    logic               in_range;
    logic [COUNT_W-1:0] cnt_inc;
    logic               count_bad;
    logic               id_fail;

    assign pg_align  = {DATA_W{1'b1}} << cfg.pg_bits;
    assign page_step = {{(DATA_W-1){1'b0}}, 1'b1} << cfg.pg_bits;
    assign cnt_inc   = cnt_reg + COUNT_W'(1);
    assign count_bad = (count_reg == '0) || (NW'(count_reg) > live_entries);
    assign id_fail   = (func_reg != FUNC_TRANSLATE) && !id_ok_reg;

    dtt_addr_unit #(
        .IW(IW),
        .NW(NW)
    ) u_addr_unit (
        .op_a      (op_a),
        .op_b      (op_b),
        .sub       (op_sub),
        .sum       (sum),
        .shift_src (rel_reg),
        .shift_amt (cfg.pg_bits),
        .limit     (live_entries),
        .idx       (idx),
        .in_range  (in_range)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == CLR_LAST) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_valid) state_next = ST_PREP;
            end
            ST_PREP: begin
                if (id_fail || (func_reg == FUNC_STUFF && count_bad)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                unique case (func_reg)
                    FUNC_TRANSLATE, FUNC_GET: state_next = in_range ? ST_READ : ST_DONE;
                    FUNC_PUT:                 state_next = ST_DONE;
                    FUNC_STUFF: begin
                        if (!in_range || cnt_inc == count_reg) state_next = ST_DONE;
                    end
                endcase
            end
            ST_READ: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake, store and shared unit controls
    always_comb begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        mem_wr_en = 1'b0;
        mem_rd_en = 1'b0;
        mem_addr  = idx;
        mem_wdata = value_reg;
        op_a      = rel_reg;
        op_b      = page_step;
        op_sub    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_wr_en = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
            end
            ST_IDLE: in_ready = 1'b1;
            ST_PREP: begin
                // translate takes the address as window relative already
                op_sub = 1'b1;
                if (func_reg == FUNC_TRANSLATE) begin
                    op_a = addr_reg;
                    op_b = '0;
                end else begin
                    op_a = addr_reg & pg_align;
                    op_b = cfg.window_base;
                end
            end
            ST_LOOK: begin
                unique case (func_reg)
                    FUNC_TRANSLATE, FUNC_GET: mem_rd_en = in_range;
                    FUNC_PUT, FUNC_STUFF:     mem_wr_en = in_range;
                endcase
            end
            ST_READ: ;
            ST_DONE: res_valid = 1'b1;
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        clr_next   = clr_reg;
        func_next  = func_reg;
        id_ok_next = id_ok_reg;
        addr_next  = addr_reg;
        value_next = value_reg;
        count_next = count_reg;
        cnt_next   = cnt_reg;
        rel_next   = rel_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_CLEAR: clr_next = clr_reg + IW'(1);
            ST_IDLE: begin
                if (in_valid) begin
                    func_next  = in_func;
                    id_ok_next = ((in_bus_id & BUS_ID_HIGH_MASK) == '0) &&
                                 (in_bus_id[31:0] == cfg.table_id);
                    addr_next  = in_addr;
                    value_next = in_entry_value;
                    count_next = in_page_count;
                    cnt_next   = '0;
                    res_next   = '0;
                end
            end
            ST_PREP: begin
                rel_next = sum;
                if (id_fail || (func_reg == FUNC_STUFF && count_bad)) begin
                    res_next.status = STATUS_ERR;
                end
            end
            ST_LOOK: begin
                unique case (func_reg)
                    FUNC_TRANSLATE: begin
                        if (!in_range) res_next.offset_mask = '1;
                    end
                    FUNC_PUT: begin
                        if (in_range) begin
                            res_next.iova        = rel_reg & pg_align;
                            res_next.phys_addr   = value_reg & pg_align;
                            res_next.offset_mask = ~pg_align;
                            res_next.perm        = value_reg[1:0];
                            res_next.notice      = (value_reg[1:0] != 2'b00) ?
                                                   NOTICE_MAP : NOTICE_UNMAP;
                        end else begin
                            res_next.status = STATUS_ERR;
                        end
                    end
                    FUNC_GET: begin
                        if (!in_range) res_next.status = STATUS_ERR;
                    end
                    FUNC_STUFF: begin
                        if (in_range) begin
                            // advance one page per entry written
                            cnt_next = cnt_inc;
                            rel_next = sum;
                            if (cnt_inc == count_reg) begin
                                res_next.status          = STATUS_OK;
                                res_next.entries_written = cnt_inc;
                            end
                        end else begin
                            res_next.status          = STATUS_ERR;
                            res_next.entries_written = cnt_reg;
                        end
                    end
                endcase
            end
            ST_READ: begin
                if (func_reg == FUNC_GET) begin
                    res_next.entry_read = mem_rdata;
                end else begin
                    res_next.iova        = rel_reg & pg_align;
                    res_next.phys_addr   = mem_rdata & pg_align;
                    res_next.offset_mask = ~pg_align;
                    res_next.perm        = mem_rdata[1:0];
                end
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
        func_reg  <= func_next;
        id_ok_reg <= id_ok_next;
        addr_reg  <= addr_next;
        value_reg <= value_next;
        count_reg <= count_next;
        cnt_reg   <= cnt_next;
        rel_reg   <= rel_next;
        res_reg   <= res_next;
    end

    assign res = res_reg;

endmodule

@@ src/dma_tce_translation_table.sv @@
// Translation table of TABLE_DEPTH 64-bit entries behind one shared adder and shifter.
// Each request walks a small sequencer: accept, address prepare (subtract window base,
// except for a translate), index and range check, then a store read for a translate or
// get that hits the table, and a done state that hands the result to the output register.
// A stuff run stays in the index step and writes one entry per cycle until its count is
// written or an index falls out of range; a request refused on bus id or count goes from
// address prepare straight to done. The sequencer takes the next request only once the
// result has left for the output register; a result that cannot leave holds the sequencer
// until the output register frees. The single-port store and the one index unit allow
// one request in flight at a time, though a finished result may wait in the output
// register while the next request is accepted. After reset the store is cleared one entry
// per cycle; s_axis_tready stays low until it completes.
// Configuration writes are taken at any time but must only be made while no request is
// outstanding.
module dma_tce_translation_table #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [dtt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dtt_pkg::DATA_W-1:0]      cfg_wdata,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // bus_id[63:0], addr[127:64], entry_value[191:128], page_count[202:192], zero pad
    input  logic [207:0]                    s_axis_tdata,
    // func[1:0]
    input  logic [1:0]                      s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status[0], entry_read[64:1], iova[128:65], phys_addr[192:129],
    // offset_mask[256:193], perm[258:257], notice[260:259], entries_written[271:261]
    output logic [271:0]                    m_axis_tdata
);
    import dtt_pkg::*;

    localparam int IW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW_D  = $clog2(TABLE_DEPTH + 1);
    localparam int NW    = (NW_D > COUNT_W) ? NW_D : COUNT_W;

    logic [31:0]        table_id_reg;
    logic [5:0]         pg_bits_reg;
    logic [DATA_W-1:0]  window_base_reg;
    logic [COUNT_W-1:0] entries_reg;

    cfg_t               cfg;
    logic [NW-1:0]      entries_ext;
    logic [NW-1:0]      live_entries;

    logic               res_valid;
    result_t            res;
    logic               out_free;
    logic               m_valid_reg;
    result_t            m_res_reg;

    logic               mem_wr_en, mem_rd_en;
    logic [IW-1:0]      mem_addr;
    logic [DATA_W-1:0]  mem_wdata, mem_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_id_reg    <= '0;
            pg_bits_reg     <= PAGE_SHIFT_RESET;
            window_base_reg <= '0;
            entries_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TABLE_ID:    table_id_reg    <= cfg_wdata[31:0];
                CFG_PAGE_SHIFT:  pg_bits_reg     <= cfg_wdata[5:0];
                CFG_WINDOW_BASE: window_base_reg <= cfg_wdata;
                CFG_ENTRIES:     entries_reg     <= cfg_wdata[COUNT_W-1:0];
            endcase
        end
    end

    assign cfg.table_id    = table_id_reg;
    assign cfg.pg_bits     = pg_bits_reg;
    assign cfg.window_base = window_base_reg;

    // saturate the entry count at the table depth
    assign entries_ext  = NW'(entries_reg);
    assign live_entries = (entries_ext > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : entries_ext;

    dtt_seq #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .IW(IW),
        .NW(NW)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_func        (func_t'(s_axis_tuser)),
        .in_bus_id      (s_axis_tdata[63:0]),
        .in_addr        (s_axis_tdata[127:64]),
        .in_entry_value (s_axis_tdata[191:128]),
        .in_page_count  (s_axis_tdata[202:192]),
        .cfg            (cfg),
        .live_entries   (live_entries),
        .res_valid      (res_valid),
        .res            (res),
        .out_free       (out_free),
        .mem_wr_en      (mem_wr_en),
        .mem_rd_en      (mem_rd_en),
        .mem_addr       (mem_addr),
        .mem_wdata      (mem_wdata),
        .mem_rdata      (mem_rdata)
    );

    dtt_store #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .IW(IW)
    ) u_store (
        .aclk  (aclk),
        .wr_en (mem_wr_en),
        .rd_en (mem_rd_en),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // output register: hold the result until the downstream side takes it
    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid && out_free) begin
            m_res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_res_reg.entries_written, m_res_reg.notice, m_res_reg.perm,
                            m_res_reg.offset_mask, m_res_reg.phys_addr, m_res_reg.iova,
                            m_res_reg.entry_read, m_res_reg.status};

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while previous one still in progress");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && out_free) |=> m_axis_tvalid)
        else $error("finished result not moved to output register");

    a_store_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_wr_en && mem_rd_en) && !(mem_wr_en && s_axis_tready))
        else $error("store access clash or write while accepting");

endmodule

@@ tb/tce_answer_checker.sv @@
module tce_answer_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [dtt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dtt_pkg::DATA_W-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // bus_id[63:0], addr[127:64], entry_value[191:128], page_count[202:192], zero pad
    input  logic [207:0]                  s_tdata,
    // func[1:0]
    input  logic [1:0]                    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // status[0], entry_read[64:1], iova[128:65], phys_addr[192:129],
    // offset_mask[256:193], perm[258:257], notice[260:259], entries_written[271:261]
    input  logic [271:0]                  m_tdata,
    output int                            mismatch_count,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import dtt_pkg::*;

    localparam int DEPTH = 1024;

    logic [63:0] shadow_tce [DEPTH];
    logic [31:0] id_reg;
    logic [5:0]  shift_reg;
    logic [63:0] base_reg;
    logic [10:0] live_reg;

    result_t due_answers [$];
    result_t want;

    initial mismatch_count = 0;
    initial pending = 0;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
        mismatch_count++;
        $display("%0t: %s mismatch: got %h, want %h", $time, what, got, exp_val);
    endtask

    function automatic result_t predict_answer(input func_t f, input logic [63:0] bus,
                                               input logic [63:0] addr,
                                               input logic [63:0] val,
                                               input logic [10:0] cnt);
        result_t     r;
        logic [63:0] mask;
        logic [63:0] idx;
        logic [63:0] a;
        logic [63:0] step;
        logic [63:0] e;
        logic [10:0] n;
        logic [10:0] done;
        logic        stop;
        r = '0;
        mask = ~((64'd1 << shift_reg) - 64'd1);
        n = (live_reg > 11'd1024) ? 11'd1024 : live_reg;

        if (f == FUNC_TRANSLATE) begin
            idx = addr >> shift_reg;
            if (idx < {53'd0, n}) begin
                e = shadow_tce[idx[9:0]];
                r.iova        = addr & mask;
                r.phys_addr   = e & mask;
                r.offset_mask = ~mask;
                r.perm        = e[1:0];
            end else begin
                r.offset_mask = '1;
            end
            return r;
        end

        if (bus[63:32] != 32'd0 || bus[31:0] != id_reg) begin
            r.status = STATUS_ERR;
            return r;
        end
        a = addr & mask;

        case (f)
            FUNC_PUT: begin
                idx = (a - base_reg) >> shift_reg;
                if (idx >= {53'd0, n}) begin
                    r.status = STATUS_ERR;
                end else begin
                    shadow_tce[idx[9:0]] = val;
                    r.iova        = (a - base_reg) & mask;
                    r.phys_addr   = val & mask;
                    r.offset_mask = ~mask;
                    r.perm        = val[1:0];
                    r.notice      = (val[1:0] != 2'd0) ? NOTICE_MAP : NOTICE_UNMAP;
                end
            end
            FUNC_GET: begin
                idx = (a - base_reg) >> shift_reg;
                if (idx >= {53'd0, n})
                    r.status = STATUS_ERR;
                else
                    r.entry_read = shadow_tce[idx[9:0]];
            end
            default: begin
                r.status = STATUS_ERR;
                if (cnt <= n && cnt != 11'd0) begin
                    step = 64'd1 << shift_reg;
                    done = '0;
                    stop = 1'b0;
                    // walk the run, one page per entry, until the count or a bad index
                    while (done < cnt && !stop) begin
                        idx = (a - base_reg) >> shift_reg;
                        if (idx >= {53'd0, n}) begin
                            stop = 1'b1;
                            r.status = STATUS_ERR;
                        end else begin
                            shadow_tce[idx[9:0]] = val;
                            r.status = STATUS_OK;
                            a = a + step;
                            done = done + 11'd1;
                        end
                    end
                    r.entries_written = done;
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            id_reg    <= '0;
            shift_reg <= PAGE_SHIFT_RESET;
            base_reg  <= '0;
            live_reg  <= '0;
            for (int k = 0; k < DEPTH; k++)
                shadow_tce[k] = '0;
            due_answers.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_TABLE_ID:    id_reg    <= cfg_wdata[31:0];
                    CFG_PAGE_SHIFT:  shift_reg <= cfg_wdata[5:0];
                    CFG_WINDOW_BASE: base_reg  <= cfg_wdata;
                    default:         live_reg  <= cfg_wdata[10:0];
                endcase
            end

            if (m_tvalid && m_tready) begin
                if (due_answers.size() == 0) begin
                    flag_mismatch("unrequested result", m_tdata[63:0], '0);
                end else begin
                    want = due_answers.pop_front();
                    if (m_tdata[0] !== want.status)
                        flag_mismatch("status", 64'(m_tdata[0]), 64'(want.status));
                    if (m_tdata[64:1] !== want.entry_read)
                        flag_mismatch("entry_read", m_tdata[64:1], want.entry_read);
                    if (m_tdata[128:65] !== want.iova)
                        flag_mismatch("iova", m_tdata[128:65], want.iova);
                    if (m_tdata[192:129] !== want.phys_addr)
                        flag_mismatch("phys_addr", m_tdata[192:129], want.phys_addr);
                    if (m_tdata[256:193] !== want.offset_mask)
                        flag_mismatch("offset_mask", m_tdata[256:193], want.offset_mask);
                    if (m_tdata[258:257] !== want.perm)
                        flag_mismatch("perm", 64'(m_tdata[258:257]), 64'(want.perm));
                    if (m_tdata[260:259] !== want.notice)
                        flag_mismatch("notice", 64'(m_tdata[260:259]), 64'(want.notice));
                    if (m_tdata[271:261] !== want.entries_written)
                        flag_mismatch("entries_written", 64'(m_tdata[271:261]),
                                      64'(want.entries_written));
                end
            end

            if (s_tvalid && s_tready)
                due_answers.push_back(predict_answer(func_t'(s_tuser), s_tdata[63:0],
                                                     s_tdata[127:64], s_tdata[191:128],
                                                     s_tdata[202:192]));
        end
        pending = due_answers.size();
    end

endmodule

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dtt_pkg::*;

    localparam int          CYCLE_LIMIT = 600000;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [63:0] PAGE        = 64'h1000;
    localparam logic [63:0] WIN_A       = 64'h0000_0001_0000_0000;

    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         cfg_wr_en     = 1'b0;
    logic [1:0]   cfg_index     = CFG_TABLE_ID;
    logic [63:0]  cfg_wdata     = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [207:0] s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = FUNC_TRANSLATE;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [271:0] m_axis_tdata;

    int mismatch_count;
    int pending;
    int cycle_count   = 0;
    int send_gap_pct  = 0;
    int recv_idle_pct = 0;
    int hold_asked    = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    // settings as last written, for aiming requests into the window
    logic [31:0] tid_now  = '0;
    logic [5:0]  ps_now   = PAGE_SHIFT_RESET;
    logic [63:0] base_now = '0;
    int          live_now = 0;

    dma_tce_translation_table #(
        .TABLE_DEPTH(1024)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    tce_answer_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_axis_tvalid),
        .s_tready      (s_axis_tready),
        .s_tdata       (s_axis_tdata),
        .s_tuser       (s_axis_tuser),
        .m_tvalid      (m_axis_tvalid),
        .m_tready      (m_axis_tready),
        .m_tdata       (m_axis_tdata),
        .mismatch_count(mismatch_count),
        .pending       (pending)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off whenever one is asked for
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_asked != hold_served) begin
            hold_served   <= hold_asked;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // leaves tvalid high after the handshake; drop_request lowers it
    task automatic send_request(input func_t f, input logic [63:0] bus,
                                input logic [63:0] addr, input logic [63:0] val,
                                input logic [10:0] cnt);
        if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(0, 99) < send_gap_pct)
                @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {5'd0, cnt, val, addr, bus};
        do
            @(posedge aclk);
        while (!s_axis_tready);
        @(negedge aclk);
    endtask

    task automatic drop_request();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        while (pending != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
    endtask

    task automatic apply_settings(input logic [63:0] tid, input logic [63:0] ps,
                                  input logic [63:0] base, input logic [63:0] ent);
        write_reg(CFG_TABLE_ID, tid);
        write_reg(CFG_PAGE_SHIFT, ps);
        write_reg(CFG_WINDOW_BASE, base);
        write_reg(CFG_ENTRIES, ent);
        cfg_wr_en <= 1'b0;
        tid_now  = tid[31:0];
        ps_now   = ps[5:0];
        base_now = base;
        live_now = (ent[10:0] > 11'd1024) ? 1024 : int'(ent[10:0]);
    endtask

    initial begin : stimulus
        func_t       f;
        logic [63:0] bus;
        logic [63:0] addr;
        logic [63:0] val;
        logic [63:0] idx;
        logic [63:0] offs;
        logic [10:0] cnt;
        int          pick;
        int          roll;

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        send_gap_pct  = 6;
        recv_idle_pct = 66;

        // table disabled after reset: miss and refuse
        send_request(FUNC_TRANSLATE, '0, '0, '0, '0);
        send_request(FUNC_PUT, '0, '0, 64'h5003, '0);
        drop_request();
        drain_results();

        apply_settings(64'hFFFF_FFFF, 64'd12, WIN_A, 64'd1024);
        send_request(FUNC_PUT, 64'hFFFF_FFFF, WIN_A, '1, '0);
        send_request(FUNC_PUT, 64'hFFFF_FFFF, WIN_A + 1023 * PAGE + 64'h7ab,
                     64'h1234_5678_9abc_d000, '0);
        send_request(FUNC_PUT, 64'hFFFF_FFFF, WIN_A + 1024 * PAGE, 64'h77, '0);
        send_request(FUNC_PUT, 64'h1_FFFF_FFFF, WIN_A, 64'h77, '0);
        send_request(FUNC_PUT, '0, WIN_A, 64'h77, '0);
        send_request(FUNC_PUT, 64'hFFFF_FFFF, WIN_A + 5 * PAGE, 64'hABCD_E001, 11'h7FF);
        send_request(FUNC_PUT, 64'hFFFF_FFFF, WIN_A + 6 * PAGE, 64'h8000_0002, '0);
        send_request(FUNC_GET, 64'hFFFF_FFFF, WIN_A, '0, '0);
        send_request(FUNC_GET, 64'hFFFF_FFFF, WIN_A + 1023 * PAGE + 64'hfff, '0, '0);
        send_request(FUNC_GET, 64'hFFFF_FFFF, WIN_A + 1024 * PAGE, '0, '0);
        send_request(FUNC_GET, 64'hFFFF_FFFE, WIN_A + 5 * PAGE, '0, '0);
        send_request(FUNC_TRANSLATE, '0, '0, '0, '0);
        send_request(FUNC_TRANSLATE, '0, 1023 * PAGE + 64'hfff, '0, '0);
        send_request(FUNC_TRANSLATE, '0, 1024 * PAGE, '0, '0);
        send_request(FUNC_TRANSLATE, '0, '1, '0, '0);
        // stuff: empty run, run longer than the table, run off the end, below the window
        send_request(FUNC_STUFF, 64'hFFFF_FFFF, WIN_A, 64'h11, 11'd0);
        send_request(FUNC_STUFF, 64'hFFFF_FFFF, WIN_A, 64'h11, 11'd1025);
        send_request(FUNC_STUFF, 64'hFFFF_FFFF, WIN_A + 1022 * PAGE, 64'h22, 11'd4);
        send_request(FUNC_STUFF, 64'hFFFF_FFFF, WIN_A - PAGE, 64'h33, 11'd1);
        send_request(FUNC_STUFF, 64'hFFFF_FFFF, WIN_A, 64'hFEED_0003, 11'd1024);
        send_request(FUNC_GET, 64'hFFFF_FFFF, WIN_A + 500 * PAGE, '0, '0);

        for (int phase = 0; phase < 8; phase++) begin
            drop_request();
            drain_results();
            case (phase)
                0: apply_settings({$urandom, $urandom}, 64'd12,
                                  {$urandom, $urandom}, 64'd1024);
                1: apply_settings(64'd0, 64'd0, {$urandom, $urandom}, 64'h7FF);
                2: apply_settings(64'hFFFF_FFFF, '1, 64'd0, 64'd2);
                3: apply_settings({$urandom, $urandom}, 64'($urandom_range(0, 20)),
                                  {$urandom, $urandom}, 64'($urandom_range(1, 1024)));
                4: apply_settings(64'($urandom), 64'd16, '1, 64'd64);
                5: apply_settings(64'($urandom), 64'($urandom_range(0, 63)),
                                  {$urandom, $urandom}, 64'($urandom_range(0, 2047)));
                6: apply_settings(64'd0, 64'd12, 64'd0, 64'd1024);
                default: apply_settings(64'($urandom), 64'd0, {$urandom, $urandom}, 64'd0);
            endcase
            if (phase < 3) begin
                send_gap_pct  = 6;
                recv_idle_pct = 66;
            end else if (phase < 6) begin
                send_gap_pct  = 66;
                recv_idle_pct = 6;
            end else begin
                send_gap_pct  = 0;
                recv_idle_pct = 0;
            end
            // stall the result side for a long stretch while requests keep coming
            if (phase == 1)
                hold_asked++;

            for (int k = 0; k < 125; k++) begin
                f    = func_t'($urandom_range(0, 3));
                cnt  = 11'($urandom_range(0, 2047));
                val  = {$urandom, $urandom};
                pick = int'($urandom_range(0, 99));
                idx  = (pick < 50) ? 64'($urandom_range(0, 15)) :
                                     64'($urandom_range(0, live_now + 1));
                offs = {$urandom, $urandom} & ((64'd1 << ps_now) - 64'd1);
                if (f == FUNC_TRANSLATE)
                    addr = (idx << ps_now) | offs;
                else
                    addr = base_now + (idx << ps_now) + offs;
                if (pick >= 90)
                    addr = {$urandom, $urandom};

                bus  = {32'd0, tid_now};
                roll = int'($urandom_range(0, 99));
                if (roll < 5)
                    bus = {$urandom, $urandom};
                else if (roll < 10)
                    bus[32 + $urandom_range(0, 31)] = 1'b1;
                else if (roll < 13)
                    bus[$urandom_range(0, 31)] = ~bus[$urandom_range(0, 31)];

                // keep most runs short; long ones are rare
                if (f == FUNC_STUFF) begin
                    roll = int'($urandom_range(0, 99));
                    if (roll < 85)
                        cnt = 11'($urandom_range(1, 8));
                    else if (roll < 88)
                        cnt = '0;
                    else if (roll < 90 && live_now > 0)
                        cnt = 11'($urandom_range(1, live_now));
                end
                send_request(f, bus, addr, val, cnt);
            end
        end

        drop_request();
        drain_results();
        repeat (16) @(negedge aclk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
src/dtt_pkg.sv
src/dtt_store.sv
src/dtt_addr_unit.sv
src/dtt_seq.sv
src/dma_tce_translation_table.sv
tb/tce_answer_checker.sv
tb/tb.sv
